// ===== src/lfu_pkg.sv =====
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int CNT_W  = COUNT_BITS;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int LIM_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // One slot as seen through the scan read port.
  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic [IDX_W-1:0]  rank;
  } slot_t;

  // What one pass over the slots found.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [DATA_W-1:0] hit_data;
    logic [CNT_W-1:0]  hit_cnt;
    logic [IDX_W-1:0]  hit_rank;
    logic              vic_found;
    logic [IDX_W-1:0]  vic_idx;
    logic [CNT_W-1:0]  vic_cnt;
    logic [IDX_W-1:0]  vic_rank;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } scan_res_t;

  // One commit to the entry store.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  slot;
    logic              age_all;
    logic [IDX_W-1:0]  ref_rank;
    logic              wr_key;
    logic              wr_data;
    logic              set_vld;
    logic              inc_occ;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
  } upd_t;

endpackage

// ===== src/lfu_scan.sv =====
module lfu_scan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  logic                    step,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  lfu_pkg::slot_t          slot,
  input  logic [lfu_pkg::KEY_W-1:0] key_cmp,
  output lfu_pkg::scan_res_t      res
);

  lfu_pkg::scan_res_t res_r, res_nxt;

  logic key_eq;
  logic vic_better;

  assign key_eq = (slot.key == key_cmp);

  // Lowest count wins; among equal counts the larger rank is older.
  assign vic_better = !res_r.vic_found || (slot.cnt < res_r.vic_cnt) ||
                      ((slot.cnt == res_r.vic_cnt) && (slot.rank > res_r.vic_rank));

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt.hit        = 1'b0;
      res_nxt.vic_found  = 1'b0;
      res_nxt.free_found = 1'b0;
    end else if (step) begin
      if (slot.vld) begin
        if (!res_r.hit && key_eq) begin
          res_nxt.hit      = 1'b1;
          res_nxt.hit_idx  = idx;
          res_nxt.hit_data = slot.data;
          res_nxt.hit_cnt  = slot.cnt;
          res_nxt.hit_rank = slot.rank;
        end
        if (vic_better) begin
          res_nxt.vic_found = 1'b1;
          res_nxt.vic_idx   = idx;
          res_nxt.vic_cnt   = slot.cnt;
          res_nxt.vic_rank  = slot.rank;
        end
      end else if (!res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/lfu_store.sv =====
module lfu_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lfu_pkg::IDX_W-1:0] rd_idx,
  output lfu_pkg::slot_t            rd_slot,
  input  lfu_pkg::upd_t             upd,
  output logic [lfu_pkg::OCC_W-1:0] occupied
);

  logic [lfu_pkg::ENTRIES-1:0]  valid_r, valid_nxt;
  logic [lfu_pkg::OCC_W-1:0]    occupied_r, occupied_nxt;
  logic [lfu_pkg::KEY_W-1:0]    key_r  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]   data_r [lfu_pkg::ENTRIES];
  logic [lfu_pkg::CNT_W-1:0]    cnt_r  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::IDX_W-1:0]    rank_r [lfu_pkg::ENTRIES];

  always_comb begin
    rd_slot.vld  = valid_r[rd_idx];
    rd_slot.key  = key_r[rd_idx];
    rd_slot.data = data_r[rd_idx];
    rd_slot.cnt  = cnt_r[rd_idx];
    rd_slot.rank = rank_r[rd_idx];
  end

  always_comb begin
    valid_nxt    = valid_r;
    occupied_nxt = occupied_r;
    if (upd.en && upd.set_vld) begin
      valid_nxt[upd.slot] = 1'b1;
    end
    if (upd.en && upd.inc_occ) begin
      occupied_nxt = occupied_r + lfu_pkg::OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occupied_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      occupied_r <= occupied_nxt;
    end
  end

  // The touched slot becomes most recent; every other live slot that was
  // more recent than it (or all of them, on a fresh insert) ages by one.
  always_ff @(posedge clk) begin
    if (upd.en) begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
        if (lfu_pkg::IDX_W'(i) == upd.slot) begin
          rank_r[i] <= '0;
          cnt_r[i]  <= upd.cnt;
          if (upd.wr_key) begin
            key_r[i] <= upd.key;
          end
          if (upd.wr_data) begin
            data_r[i] <= upd.data;
          end
        end else if (valid_r[i] && (upd.age_all || (rank_r[i] < upd.ref_rank))) begin
          rank_r[i] <= rank_r[i] + lfu_pkg::IDX_W'(1);
        end
      end
    end
  end

  assign occupied = occupied_r;

`ifndef ASSERT_OFF
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occupied_r))
    else $error("occupancy count differs from the number of live slots");
`endif

endmodule

// ===== src/lfu_cache_with_lru_tiebreak.sv =====
// Fully associative key/value store with least-frequently-used replacement
// and least-recently-used tie-break among equal use counts. Each transfer on
// the input channel is a get or a put and yields exactly one result transfer
// (hit flag, and the stored value on a get hit, else zero). A new item is
// taken only once the last one has committed: one shared compare step looks at
// one slot per cycle over all ENTRIES slots (key match, eviction victim,
// first free slot), then the update is committed to the store once the
// output register is free. The result waits there; a new item may be taken
// while it is unclaimed. The capacity register may be written whenever no
// item is in flight and takes effect on the next item.
module lfu_cache_with_lru_tiebreak (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [lfu_pkg::KEY_W-1:0]  in_key,
  input  logic [lfu_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lfu_pkg::DATA_W-1:0] out_read_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_capacity
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [lfu_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                         cmd_r;
  logic [lfu_pkg::KEY_W-1:0]    key_r;
  logic [lfu_pkg::DATA_W-1:0]   value_r;
  logic [lfu_pkg::CAP_W-1:0]    cap_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r;
  logic [lfu_pkg::DATA_W-1:0]   out_value_r;

  logic                         in_fire;
  logic                         commit;
  logic                         last_slot;
  logic [lfu_pkg::LIM_W-1:0]    cap_ext;
  logic [lfu_pkg::LIM_W-1:0]    lim;
  logic [lfu_pkg::LIM_W-1:0]    occ_ext;
  logic [lfu_pkg::OCC_W-1:0]    occupied;
  lfu_pkg::slot_t               rd_slot;
  lfu_pkg::scan_res_t           res;
  lfu_pkg::upd_t                upd;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign commit    = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign last_slot = (idx_r == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1));

  lfu_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (in_fire),
    .step    (state_r == ST_SCAN),
    .idx     (idx_r),
    .slot    (rd_slot),
    .key_cmp (key_r),
    .res     (res)
  );

  lfu_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_slot  (rd_slot),
    .upd      (upd),
    .occupied (occupied)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + lfu_pkg::IDX_W'(1);
        if (last_slot) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Capacities beyond the slot count behave as the slot count.
  always_comb begin
    cap_ext = lfu_pkg::LIM_W'(cap_r);
    occ_ext = lfu_pkg::LIM_W'(occupied);
    lim     = (cap_ext > lfu_pkg::LIM_W'(lfu_pkg::ENTRIES)) ?
              lfu_pkg::LIM_W'(lfu_pkg::ENTRIES) : cap_ext;
  end

  // Evicting a victim and inserting into its slot ages the other slots
  // exactly as a touch of the victim would, so both share one commit form.
  always_comb begin
    upd      = '0;
    upd.key  = key_r;
    upd.data = value_r;
    if (commit) begin
      if (res.hit) begin
        upd.en       = 1'b1;
        upd.slot     = res.hit_idx;
        upd.ref_rank = res.hit_rank;
        upd.wr_data  = (cmd_r == lfu_pkg::CMD_PUT);
        upd.cnt      = (res.hit_cnt == lfu_pkg::CNT_MAX) ?
                       res.hit_cnt : res.hit_cnt + lfu_pkg::CNT_W'(1);
      end else if ((cmd_r == lfu_pkg::CMD_PUT) && (lim != '0)) begin
        if (occ_ext >= lim) begin
          upd.en       = res.vic_found;
          upd.slot     = res.vic_idx;
          upd.ref_rank = res.vic_rank;
          upd.wr_key   = 1'b1;
          upd.wr_data  = 1'b1;
          upd.cnt      = lfu_pkg::CNT_W'(1);
        end else begin
          upd.en      = res.free_found;
          upd.slot    = res.free_idx;
          upd.age_all = 1'b1;
          upd.wr_key  = 1'b1;
          upd.wr_data = 1'b1;
          upd.set_vld = 1'b1;
          upd.inc_occ = 1'b1;
          upd.cnt     = lfu_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cap_r       <= lfu_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_command;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (commit) begin
      out_hit_r   <= res.hit;
      out_value_r <= (res.hit && (cmd_r == lfu_pkg::CMD_GET)) ? res.hit_data : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

`ifndef ASSERT_OFF
  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN) && (idx_r == '0))
    else $error("scan did not start at the first slot");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a commit");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("commit did not present a result and return to idle");
`endif

endmodule
